[hdl/cdf_pkg.sv]
`timescale 1ns / 1ps

package cdf_pkg;

  localparam int COMP_BITS       = 16;
  localparam int FRAC_BITS       = 14;
  localparam int COORD_BITS      = FRAC_BITS + 2;
  localparam int MAG_BITS        = COMP_BITS;
  localparam int QUO_BITS        = FRAC_BITS + 1;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = (FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int STEP_BITS       = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [2:0]                   face;
    logic signed [COORD_BITS-1:0] coord_u;
    logic signed [COORD_BITS-1:0] coord_v;
    logic                         invalid;
  } out_t;

  // one quotient lane of the restoring divider
  typedef struct packed {
    logic [MAG_BITS-1:0] rem;
    logic [QUO_BITS-1:0] quo;
    logic                neg;
  } lane_t;

  typedef struct packed {
    face_t               face;
    logic                invalid;
    logic [MAG_BITS-1:0] major;
    logic [STEP_BITS-1:0] step;
    lane_t               u;
    lane_t               v;
  } work_t;

  function automatic logic [MAG_BITS-1:0] magnitude(input logic [COMP_BITS-1:0] c);
    magnitude = c[COMP_BITS-1] ? (~c + COMP_BITS'(1)) : c;
  endfunction

  // shift remainder, trial-subtract the major magnitude, shift in one quotient bit
  function automatic lane_t div_step(input lane_t l, input logic [MAG_BITS-1:0] major);
    logic [MAG_BITS:0] rem2;
    logic [MAG_BITS:0] diff;
    logic              take;
    lane_t             r;
    rem2  = {l.rem, 1'b0};
    diff  = rem2 - {1'b0, major};
    take  = (rem2 >= {1'b0, major});
    r     = l;
    r.rem = take ? diff[MAG_BITS-1:0] : rem2[MAG_BITS-1:0];
    r.quo = {l.quo[QUO_BITS-2:0], take};
    div_step = r;
  endfunction

endpackage

[hdl/cube_direction_to_face.sv]
`timescale 1ns / 1ps

// Cube map face selection. Takes one direction request per cycle while in_stall is low
// and returns the face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z, 5 -z) with two Q1.14 face
// coordinates, truncated toward zero; an all-zero vector gives face 5, zero coordinates
// and invalid set. One stage picks the major axis, the restoring dividers produce
// up to three quotient bits per stage over DIV_STAGES stages, and a last stage
// applies the signs. Each stage holds its request only while the stage after it is
// full and stalled, so bubbles close up under stall.
module cube_direction_to_face (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cdf_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cdf_pkg::out_t  out_data
);

  logic           vld   [cdf_pkg::DIV_STAGES+1];
  logic           stl   [cdf_pkg::DIV_STAGES+1];
  cdf_pkg::work_t wrk   [cdf_pkg::DIV_STAGES+1];

  cdf_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (vld[0]),
    .dn_stall (stl[0]),
    .dn_data  (wrk[0])
  );

  for (genvar g = 0; g < cdf_pkg::DIV_STAGES; g++) begin : g_div
    cdf_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_stall (stl[g]),
      .up_data  (wrk[g]),
      .dn_valid (vld[g+1]),
      .dn_stall (stl[g+1]),
      .dn_data  (wrk[g+1])
    );
  end

  cdf_sign u_sign (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[cdf_pkg::DIV_STAGES]),
    .up_stall (stl[cdf_pkg::DIV_STAGES]),
    .up_data  (wrk[cdf_pkg::DIV_STAGES]),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

  localparam logic signed [cdf_pkg::COORD_BITS-1:0] ONE =
    cdf_pkg::COORD_BITS'(1) << cdf_pkg::FRAC_BITS;

  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |->
      out_data.coord_u == '0 && out_data.coord_v == '0 &&
      out_data.face == cdf_pkg::FACE_NZ)
    else $error("zero vector result malformed");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.coord_u <= ONE && out_data.coord_u >= -ONE &&
      out_data.coord_v <= ONE && out_data.coord_v >= -ONE)
    else $error("face coordinate outside [-1,1]");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

[hdl/cdf_select.sv]
`timescale 1ns / 1ps

module cdf_select (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_stall,
  input  cdf_pkg::in_t    up_data,
  output logic            dn_valid,
  input  logic            dn_stall,
  output cdf_pkg::work_t  dn_data
);

  logic                          valid_r;
  cdf_pkg::work_t                data_r;
  cdf_pkg::work_t                data_nxt;
  logic [cdf_pkg::MAG_BITS-1:0]  ax;
  logic [cdf_pkg::MAG_BITS-1:0]  ay;
  logic [cdf_pkg::MAG_BITS-1:0]  az;
  logic [cdf_pkg::MAG_BITS-1:0]  mu;
  logic [cdf_pkg::MAG_BITS-1:0]  mv;
  logic                          x_neg;
  logic                          y_neg;
  logic                          z_neg;
  logic                          q0_u;
  logic                          q0_v;

  assign x_neg = up_data.dir_x[cdf_pkg::COMP_BITS-1];
  assign y_neg = up_data.dir_y[cdf_pkg::COMP_BITS-1];
  assign z_neg = up_data.dir_z[cdf_pkg::COMP_BITS-1];
  assign ax    = cdf_pkg::magnitude(up_data.dir_x);
  assign ay    = cdf_pkg::magnitude(up_data.dir_y);
  assign az    = cdf_pkg::magnitude(up_data.dir_z);

  always_comb begin
    data_nxt         = '0;
    data_nxt.invalid = (ax == '0) && (ay == '0) && (az == '0);
    mu               = ax;
    mv               = ay;
    if (ax > ay && ax > az) begin
      data_nxt.major = ax;
      mu             = az;
      mv             = ay;
      data_nxt.v.neg = !y_neg;
      if (!x_neg) begin
        data_nxt.face  = cdf_pkg::FACE_PX;
        data_nxt.u.neg = !z_neg;
      end else begin
        data_nxt.face  = cdf_pkg::FACE_NX;
        data_nxt.u.neg = z_neg;
      end
    end else if (ay > az) begin
      data_nxt.major = ay;
      mu             = ax;
      mv             = az;
      data_nxt.u.neg = x_neg;
      if (!y_neg) begin
        data_nxt.face  = cdf_pkg::FACE_PY;
        data_nxt.v.neg = z_neg;
      end else begin
        data_nxt.face  = cdf_pkg::FACE_NY;
        data_nxt.v.neg = !z_neg;
      end
    end else begin
      // a zero vector lands here too and reports the negative z face
      data_nxt.major = az;
      mu             = ax;
      mv             = ay;
      data_nxt.v.neg = !y_neg;
      if (!z_neg && az != '0) begin
        data_nxt.face  = cdf_pkg::FACE_PZ;
        data_nxt.u.neg = x_neg;
      end else begin
        data_nxt.face  = cdf_pkg::FACE_NZ;
        data_nxt.u.neg = !x_neg;
      end
    end
    // integer quotient bit: a minor can only reach the major by equalling it
    q0_u             = (mu == data_nxt.major);
    q0_v             = (mv == data_nxt.major);
    data_nxt.u.quo   = cdf_pkg::QUO_BITS'(q0_u);
    data_nxt.v.quo   = cdf_pkg::QUO_BITS'(q0_v);
    data_nxt.u.rem   = q0_u ? '0 : mu;
    data_nxt.v.rem   = q0_v ? '0 : mv;
    data_nxt.step    = '0;
  end

  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[hdl/cdf_div_stage.sv]
`timescale 1ns / 1ps

module cdf_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_stall,
  input  cdf_pkg::work_t  up_data,
  output logic            dn_valid,
  input  logic            dn_stall,
  output cdf_pkg::work_t  dn_data
);

  logic           valid_r;
  cdf_pkg::work_t data_r;
  cdf_pkg::work_t data_nxt;

  always_comb begin
    data_nxt = up_data;
    for (int s = 0; s < cdf_pkg::STEPS_PER_STAGE; s++) begin
      // stop once every fraction bit is produced
      if (data_nxt.step < cdf_pkg::STEP_BITS'(cdf_pkg::FRAC_BITS)) begin
        data_nxt.u    = cdf_pkg::div_step(data_nxt.u, data_nxt.major);
        data_nxt.v    = cdf_pkg::div_step(data_nxt.v, data_nxt.major);
        data_nxt.step = data_nxt.step + cdf_pkg::STEP_BITS'(1);
      end
    end
  end

  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[hdl/cdf_sign.sv]
`timescale 1ns / 1ps

module cdf_sign (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_stall,
  input  cdf_pkg::work_t  up_data,
  output logic            dn_valid,
  input  logic            dn_stall,
  output cdf_pkg::out_t   dn_data
);

  logic                            valid_r;
  cdf_pkg::out_t                   data_r;
  cdf_pkg::out_t                   data_nxt;
  logic [cdf_pkg::COORD_BITS-1:0]  qu;
  logic [cdf_pkg::COORD_BITS-1:0]  qv;

  assign qu = cdf_pkg::COORD_BITS'(up_data.u.quo);
  assign qv = cdf_pkg::COORD_BITS'(up_data.v.quo);

  always_comb begin
    data_nxt         = '0;
    data_nxt.face    = up_data.face;
    data_nxt.invalid = up_data.invalid;
    // drop the divider result for a zero vector
    if (!up_data.invalid) begin
      data_nxt.coord_u = up_data.u.neg ? -qu : qu;
      data_nxt.coord_v = up_data.v.neg ? -qv : qv;
    end
  end

  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
